// ===== sv/rrtd_pkg.sv =====
// shared types, constants and helpers of the round robin task dispatcher
`timescale 1ns / 1ps
`default_nettype none

package rrtd_pkg;

  localparam int NUM_SLOTS = 4;
  localparam int ADDR_BITS = 16;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam int IN_TDATA_W  = ((ADDR_BITS + 7) / 8) * 8;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = ((SLOT_W + ADDR_BITS + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 3;

  typedef enum logic [1:0] {
    SS_DEAD    = 2'd0,
    SS_READY   = 2'd1,
    SS_RUNNING = 2'd2
  } slot_state_e;

  typedef enum logic [1:0] {
    CMD_CREATE    = 2'd0,
    CMD_START     = 2'd1,
    CMD_YIELD     = 2'd2,
    CMD_TERMINATE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_IGNORED  = 2'd2,
    STS_NO_READY = 2'd3
  } status_e;

  // access to the slot table from the sequencer
  typedef struct packed {
    logic                 st_we;
    logic                 code_we;
    logic [SLOT_W-1:0]    idx;
    slot_state_e          st;
    logic [ADDR_BITS-1:0] code;
    logic [SLOT_W-1:0]    rd_idx;
  } tbl_req_t;

  // finished result from the sequencer
  typedef struct packed {
    logic              done;
    status_e           status;
    logic              switched;
    logic              active;
    logic [SLOT_W-1:0] slot;
  } seq_res_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(NUM_SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/round_robin_task_dispatcher_top.sv =====
// top level of the round robin task dispatcher
//
//  channel  dir  tdata                         tuser
//  s_axis   in   [15:0] code_addr              [1:0] command
//  m_axis   out  [1:0] running_slot,           [1:0] status, [2] switched
//                [17:2] running_code
//
// the slot scan visits one table slot per cycle
// s_axis_tready_o is high only while the sequencer is idle
// the result sits in an output register; the next item is taken while it waits
// reset leaves every slot dead and the scheduler inactive
`timescale 1ns / 1ps
`default_nettype none

module round_robin_task_dispatcher_top
  import rrtd_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // code_addr
  input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser_i,   // command
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,   // running_slot, running_code
  output logic [OUT_TUSER_W-1:0]      m_axis_tuser_o    // status, switched
);

  tbl_req_t             req;
  seq_res_t             res;
  slot_state_e          st_rd;
  logic [ADDR_BITS-1:0] code_rd;
  logic                 out_free;

  logic                 out_valid_q;
  status_e              out_status_q;
  logic                 out_switched_q;
  logic [SLOT_W-1:0]    out_slot_q;
  logic [ADDR_BITS-1:0] out_code_q;

  assign out_free = !out_valid_q || m_axis_tready_i;

  rrtd_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_cmd_i   (s_axis_tuser_i[1:0]),
    .in_addr_i  (s_axis_tdata_i[ADDR_BITS-1:0]),
    .in_ready_o (s_axis_tready_o),
    .out_free_i (out_free),
    .st_i       (st_rd),
    .req_o      (req),
    .res_o      (res)
  );

  rrtd_slot_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .st_o   (st_rd),
    .code_o (code_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.done) begin
      out_status_q   <= res.status;
      out_switched_q <= res.switched;
      out_slot_q     <= res.active ? res.slot : '0;
      out_code_q     <= res.active ? code_rd : '0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_code_q, out_slot_q});
  assign m_axis_tuser_o  = {out_switched_q, out_status_q};

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("dispatcher ready right after taking an item");

  a_switch_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[2] |-> m_axis_tuser_o[1:0] == STS_OK)
    else $error("switch reported with a non-ok status");

  a_inactive_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[1:0] == STS_IGNORED ||
                        m_axis_tuser_o[1:0] == STS_NO_READY)
    |-> m_axis_tdata_o == '0)
    else $error("running task shown while scheduler inactive");
`endif

endmodule

`default_nettype wire

// ===== sv/rrtd_slot_table.sv =====
// slot table: per-slot state flops and code address memory
`timescale 1ns / 1ps
`default_nettype none

module rrtd_slot_table
  import rrtd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire tbl_req_t             req_i,
  output slot_state_e               st_o,
  output logic [ADDR_BITS-1:0]      code_o
);

  slot_state_e          st_q [NUM_SLOTS];
  logic [ADDR_BITS-1:0] code_mem [NUM_SLOTS];
  logic [ADDR_BITS-1:0] code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        st_q[i] <= SS_DEAD;
      end
    end else if (req_i.st_we) begin
      st_q[req_i.idx] <= req_i.st;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.code_we) begin
      code_mem[req_i.idx] <= req_i.code;
    end
    code_q <= code_mem[req_i.rd_idx];
  end

  assign st_o   = st_q[req_i.idx];
  assign code_o = code_q;

endmodule

`default_nettype wire

// ===== sv/rrtd_seq.sv =====
// command sequencer with the shared slot scan step
`timescale 1ns / 1ps
`default_nettype none

module rrtd_seq
  import rrtd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic [1:0]           in_cmd_i,
  input  wire logic [ADDR_BITS-1:0] in_addr_i,
  output logic                      in_ready_o,
  input  wire logic                 out_free_i,
  input  wire slot_state_e          st_i,
  output tbl_req_t                  req_o,
  output seq_res_t                  res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CREATE,
    S_RELEASE,
    S_DISP,
    S_READ,
    S_OUT
  } state_e;

  state_e               state_q, state_d;
  cmd_e                 cmd_q, cmd_d;
  logic [ADDR_BITS-1:0] addr_q, addr_d;
  logic [SLOT_W-1:0]    idx_q, idx_d;
  logic [SLOT_W-1:0]    cnt_q, cnt_d;
  logic [SLOT_W-1:0]    cur_q, cur_d;
  logic [SLOT_W-1:0]    next_q, next_d;
  logic                 active_q, active_d;
  status_e              status_q, status_d;
  logic                 switched_q, switched_d;
  logic                 last_step;

  assign last_step = (cnt_q == SLOT_W'(NUM_SLOTS - 1));

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    addr_d     = addr_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    cur_d      = cur_q;
    next_d     = next_q;
    active_d   = active_q;
    status_d   = status_q;
    switched_d = switched_q;

    req_o.st_we   = 1'b0;
    req_o.code_we = 1'b0;
    req_o.idx     = idx_q;
    req_o.st      = SS_DEAD;
    req_o.code    = addr_q;
    req_o.rd_idx  = cur_q;

    res_o.done     = 1'b0;
    res_o.status   = status_q;
    res_o.switched = switched_q;
    res_o.active   = active_q;
    res_o.slot     = cur_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d      = cmd_e'(in_cmd_i);
          addr_d     = in_addr_i;
          cnt_d      = '0;
          status_d   = STS_OK;
          switched_d = 1'b0;
          case (cmd_e'(in_cmd_i))
            CMD_CREATE: begin
              idx_d   = '0;
              state_d = S_CREATE;
            end
            CMD_START: begin
              if (active_q) begin
                state_d = S_READ;
              end else begin
                idx_d   = next_q;
                state_d = S_DISP;
              end
            end
            default: begin
              if (active_q) begin
                idx_d   = cur_q;
                state_d = S_RELEASE;
              end else begin
                status_d = STS_IGNORED;
                state_d  = S_READ;
              end
            end
          endcase
        end
      end
      S_CREATE: begin
        if (st_i == SS_DEAD) begin
          req_o.st_we   = 1'b1;
          req_o.code_we = 1'b1;
          req_o.st      = SS_READY;
          state_d       = S_READ;
        end else if (last_step) begin
          status_d = STS_FULL;
          state_d  = S_READ;
        end else begin
          idx_d = slot_inc(idx_q);
          cnt_d = cnt_q + SLOT_W'(1);
        end
      end
      S_RELEASE: begin
        if (cmd_q == CMD_TERMINATE) begin
          req_o.st_we = 1'b1;
          req_o.st    = SS_DEAD;
        end else if (st_i == SS_RUNNING) begin
          req_o.st_we = 1'b1;
          req_o.st    = SS_READY;
        end
        idx_d   = next_q;
        state_d = S_DISP;
      end
      S_DISP: begin
        if (st_i == SS_READY) begin
          req_o.st_we = 1'b1;
          req_o.st    = SS_RUNNING;
          cur_d       = idx_q;
          next_d      = slot_inc(idx_q);
          active_d    = 1'b1;
          switched_d  = 1'b1;
          state_d     = S_READ;
        end else if (last_step) begin
          active_d = 1'b0;
          status_d = STS_NO_READY;
          state_d  = S_READ;
        end else begin
          idx_d = slot_inc(idx_q);
          cnt_d = cnt_q + SLOT_W'(1);
        end
      end
      S_READ: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free_i) begin
          res_o.done = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cmd_q      <= CMD_CREATE;
      addr_q     <= '0;
      idx_q      <= '0;
      cnt_q      <= '0;
      cur_q      <= '0;
      next_q     <= '0;
      active_q   <= 1'b0;
      status_q   <= STS_OK;
      switched_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cmd_q      <= cmd_d;
      addr_q     <= addr_d;
      idx_q      <= idx_d;
      cnt_q      <= cnt_d;
      cur_q      <= cur_d;
      next_q     <= next_d;
      active_q   <= active_d;
      status_q   <= status_d;
      switched_q <= switched_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

`default_nettype wire
